[design/tie_pkg.sv]
// ----------------------------------------------------------------------------
// tie_pkg: shared types and constants for the toy ISA execute unit
// Opcodes, condition codes, flag codes and the front-to-back command record.
// ----------------------------------------------------------------------------
`default_nettype none
package tie_pkg;

  localparam int DataWordsDefault = 65536;
  localparam int NumRegs          = 9;
  localparam int MaxReg           = 8;
  localparam int FirstPtrReg      = 5;
  localparam logic [15:0] IpStep  = 16'd4;

  localparam logic [7:0] OP_HALT = 8'd0;
  localparam logic [7:0] OP_MOVE = 8'd1;
  localparam logic [7:0] OP_ADD  = 8'd2;
  localparam logic [7:0] OP_SUB  = 8'd3;
  localparam logic [7:0] OP_MUL  = 8'd4;
  localparam logic [7:0] OP_DIV  = 8'd5;
  localparam logic [7:0] OP_AND  = 8'd6;
  localparam logic [7:0] OP_OR   = 8'd7;
  localparam logic [7:0] OP_NOT  = 8'd8;
  localparam logic [7:0] OP_CMP  = 8'd9;
  localparam logic [7:0] OP_JMP  = 8'd10;
  localparam logic [7:0] OP_IN   = 8'd11;
  localparam logic [7:0] OP_OUT  = 8'd12;

  localparam logic [3:0] CC_ALWAYS = 4'd0;
  localparam logic [3:0] CC_EQ     = 4'd1;
  localparam logic [3:0] CC_GT     = 4'd2;
  localparam logic [3:0] CC_LT     = 4'd3;

  localparam logic [1:0] FLAG_EQ = 2'b00;
  localparam logic [1:0] FLAG_GT = 2'b01;
  localparam logic [1:0] FLAG_LT = 2'b11;

  // classified instruction handed from front to back
  typedef struct packed {
    logic [7:0]  func;
    logic [3:0]  fr;
    logic [3:0]  bk;
    logic [15:0] imm;
    logic [15:0] inv;
    logic        bad;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_SRC, ST_WAIT_SRC, ST_RD_DST, ST_WAIT_DST,
    ST_EXEC, ST_DIV, ST_WRITE, ST_OUT
  } bstate_t;

endpackage
`default_nettype wire

[design/tie_front.sv]
// ----------------------------------------------------------------------------
// tie_front: accepts instructions, flags bad registers, two-entry queue
// Input request is classified and queued for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module tie_front
  import tie_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [47:0] in_data,
  output logic             q_valid,
  input  wire logic        q_ready,
  output cmd_t             q_cmd
);

  cmd_t       slot [2];
  logic [1:0] count;
  logic       rd_ptr, wr_ptr;
  cmd_t       cls;
  logic       push, pop;

  // classify
  always_comb begin
    cls.func = in_data[7:0];
    cls.fr   = in_data[11:8];
    cls.bk   = in_data[15:12];
    cls.imm  = in_data[31:16];
    cls.inv  = in_data[47:32];
    cls.bad  = 1'b0;
    if ((cls.func >= OP_MOVE && cls.func <= OP_CMP) || cls.func == OP_IN ||
        cls.func == OP_OUT) begin
      if (cls.fr > 4'(MaxReg)) cls.bad = 1'b1;
      if (cls.func <= OP_CMP && cls.bk > 4'(MaxReg)) cls.bad = 1'b1;
    end
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= cls;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overfilled");
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !in_ready) else $error("ready while full");
  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    count == 2'd0 |-> !pop) else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

[design/tie_divider.sv]
// ----------------------------------------------------------------------------
// tie_divider: 16-bit signed divide, truncating, one quotient bit per cycle
// Restoring division on magnitudes, sign fixed at the end.
// ----------------------------------------------------------------------------
`default_nettype none
module tie_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [15:0]      quotient
);

  logic [15:0] num, den, quo;
  logic [16:0] rem;
  logic [4:0]  cnt;
  logic        busy, neg;
  logic [16:0] trial;

  assign trial = {rem[15:0], num[15]} - {1'b0, den};

  // iterate
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd16;
        num  <= dividend[15] ? 16'(-dividend) : dividend;
        den  <= divisor[15] ? 16'(-divisor) : divisor;
        neg  <= dividend[15] ^ divisor[15];
        rem  <= '0;
        quo  <= '0;
      end else if (busy) begin
        num <= {num[14:0], 1'b0};
        if (!trial[16]) begin
          rem <= trial;
          quo <= {quo[14:0], 1'b1};
        end else begin
          rem <= {rem[15:0], num[15]};
          quo <= {quo[14:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? 16'(-quo) : quo;

endmodule
`default_nettype wire

[design/tie_back.sv]
// ----------------------------------------------------------------------------
// tie_back: executes queued instructions against registers and data memory
// Sequencer with two memory ports, iterative divider and an output register.
// ----------------------------------------------------------------------------
`default_nettype none
module tie_back
  import tie_pkg::*;
#(
  parameter int DATA_WORDS = DataWordsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  cmd_t             q_cmd,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [53:0]      res_data
);

  localparam int AW = $clog2(DATA_WORDS);

  bstate_t     state, state_next;
  cmd_t        cmd;
  logic [15:0] regs [NumRegs];
  logic [15:0] mem [DATA_WORDS];
  logic [AW:0] clr_addr;
  logic        clearing;
  logic [15:0] ip;
  logic [1:0]  flag;
  logic [15:0] src, dst, wval;
  logic [AW-1:0] mem_raddr;
  logic [15:0] mem_rdata;
  logic        mem_rd;
  logic        do_write, write_bk, wr_raw;
  logic        div_start, div_done;
  logic [15:0] div_q;
  logic        dz, outv;
  logic [15:0] oval;
  logic        load_src, load_dst, store_res;
  logic [3:0]  wr_reg;

  function automatic logic [AW-1:0] addr_of(input logic [15:0] v);
    return v[AW-1:0];
  endfunction

  // memory: one write port, one registered read port; cleared after reset
  always_ff @(posedge clk) begin
    if (clearing) mem[clr_addr[AW-1:0]] <= '0;
    else if (do_write && !wr_raw && wr_reg >= 4'(FirstPtrReg))
      mem[addr_of(regs[wr_reg])] <= wval;
    if (mem_rd) mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == (AW+1)'(DATA_WORDS - 1)) clearing <= 1'b0;
    end
  end

  tie_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dst), .divisor(src),
    .done(div_done), .quotient(div_q)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    mem_rd     = 1'b0;
    mem_raddr  = addr_of(regs[cmd.bk]);
    load_src   = 1'b0;
    load_dst   = 1'b0;
    div_start  = 1'b0;
    store_res  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        q_ready = !clearing && !res_valid;
        if (q_ready && q_valid) state_next = ST_RD_SRC;
      end
      ST_RD_SRC: begin
        mem_rd = 1'b1;
        state_next = ST_WAIT_SRC;
      end
      ST_WAIT_SRC: begin
        load_src = 1'b1;
        state_next = ST_RD_DST;
      end
      ST_RD_DST: begin
        mem_rd = 1'b1;
        mem_raddr = addr_of(regs[cmd.fr]);
        state_next = ST_WAIT_DST;
      end
      ST_WAIT_DST: begin
        load_dst = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd.func == OP_DIV && !cmd.bad && src != 16'd0) begin
          div_start = 1'b1;
          state_next = ST_DIV;
        end else state_next = ST_WRITE;
      end
      ST_DIV: if (div_done) state_next = ST_WRITE;
      ST_WRITE: begin
        store_res = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // operand capture
  always_ff @(posedge clk) begin
    if (q_ready && q_valid) cmd <= q_cmd;
    if (load_src) begin
      if (cmd.bk == 4'd0) src <= cmd.imm;
      else if (cmd.bk < 4'(FirstPtrReg)) src <= regs[cmd.bk];
      else src <= mem_rdata;
    end
    if (load_dst) begin
      if (cmd.fr < 4'(FirstPtrReg)) dst <= regs[cmd.fr];
      else dst <= mem_rdata;
    end
  end

  // result evaluation
  always_comb begin
    do_write = 1'b0;
    write_bk = 1'b0;
    wr_raw   = 1'b0;
    wval     = '0;
    dz       = 1'b0;
    outv     = 1'b0;
    oval     = '0;
    if (cmd.func != OP_HALT && !cmd.bad) begin
      unique case (cmd.func)
        OP_MOVE: begin
          do_write = 1'b1;
          wval = src;
          wr_raw = (cmd.bk == 4'd0);
        end
        OP_ADD: begin do_write = 1'b1; wval = dst + src; end
        OP_SUB: begin do_write = 1'b1; wval = dst - src; end
        OP_MUL: begin do_write = 1'b1; wval = 16'(dst * src); end
        OP_DIV: begin
          if (src == 16'd0) dz = 1'b1;
          else begin do_write = 1'b1; wval = div_q; end
        end
        OP_AND, OP_OR, OP_NOT: begin
          if (cmd.fr == 4'd0 && cmd.bk != 4'd0) begin
            do_write = 1'b1; write_bk = 1'b1; wval = {15'd0, src == 16'd0};
          end else if (cmd.fr != 4'd0) begin
            if (cmd.func == OP_AND) begin
              do_write = 1'b1; wval = {15'd0, dst != 0 && src != 0};
            end else if (cmd.func == OP_OR) begin
              do_write = 1'b1; wval = {15'd0, dst != 0 || src != 0};
            end else if (cmd.bk == 4'd0) begin
              do_write = 1'b1; wval = {15'd0, dst == 16'd0};
            end
          end
        end
        OP_IN: begin do_write = 1'b1; wval = cmd.inv; end
        OP_OUT: begin outv = 1'b1; oval = dst; end
        default: ;
      endcase
    end
    wr_reg = write_bk ? cmd.bk : cmd.fr;
    do_write = do_write && store_res;
  end

  // architectural state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) regs[i] <= '0;
      ip        <= '0;
      flag      <= FLAG_EQ;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (do_write && (wr_raw || wr_reg < 4'(FirstPtrReg))) regs[wr_reg] <= wval;
      if (store_res) begin
        logic [15:0] nip;
        logic [1:0]  nflag;
        nip   = ip + IpStep;
        nflag = flag;
        if (!cmd.bad && cmd.func == OP_CMP)
          nflag = ($signed(dst) == $signed(src)) ? FLAG_EQ :
                  ($signed(dst) > $signed(src)) ? FLAG_GT : FLAG_LT;
        if (cmd.func == OP_JMP &&
            (cmd.bk == CC_ALWAYS || (cmd.bk == CC_EQ && flag == FLAG_EQ) ||
             (cmd.bk == CC_GT && flag == FLAG_GT) || (cmd.bk == CC_LT && flag == FLAG_LT)))
          nip = ip + cmd.imm;
        ip   <= nip;
        flag <= nflag;
        res_data  <= {dz, cmd.bad, cmd.func == OP_HALT, oval, outv,
                      cmd.func, cmd.fr, cmd.bk, nflag, nip};
        res_valid <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_exec_while_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> state == ST_IDLE) else $error("executing during clear");
  a_div_only_on_div: assert property (@(posedge clk) disable iff (rst)
    div_start |-> cmd.func == OP_DIV && src != 16'd0) else $error("stray divide");
  a_result_once: assert property (@(posedge clk) disable iff (rst)
    store_res |=> res_valid) else $error("result lost");
`endif

endmodule
`default_nettype wire

[design/toy_isa_execute_unit_core.sv]
// ----------------------------------------------------------------------------
// toy_isa_execute_unit_core: executes decoded toy-ISA instructions one at a time
// Front end classifies and queues; back end runs memory and divide steps.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields (tdata, low bit first)
// s_axis   in   func[7:0] first_operand[11:8] second_operand[15:12]
//               immediate[31:16] in_value[47:32]
// m_axis   out  next_pointer[15:0] compare_result[17:16] instr_upper_half[33:18]
//               out_valid[34] out_value[50:35] halted[51] bad_register[52]
//               divide_by_zero[53]
// Back-end steps per instruction: read and capture source, read and capture
// destination, execute, divide if needed (one quotient bit per cycle), write,
// output; memory reads are registered. After reset, the data memory is cleared
// one word a cycle; no instruction executes until it ends (the input queue still
// fills). A stalled result holds the back end; the front queue takes items until full.
// ----------------------------------------------------------------------------
`default_nettype none
module toy_isa_execute_unit_core
  import tie_pkg::*;
#(
  parameter int DATA_WORDS = DataWordsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // func, first, second, immediate, in_value
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata    // next_pointer .. divide_by_zero, zero pad
);

  logic        q_valid, q_ready;
  cmd_t        q_cmd;
  logic [53:0] res;

  tie_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_data(s_axis_tdata), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  tie_back #(.DATA_WORDS(DATA_WORDS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_data(res)
  );

  // pack result, zero pad to whole bytes
  assign m_axis_tdata = {2'b00, res};

endmodule
`default_nettype wire

[tb/toy_isa_execute_unit_core_tb.sv]
// ----------------------------------------------------------------------------
// toy_isa_execute_unit_core_tb: self-checking bench for the execute unit
// Drives a directed instruction table and then random programs over the
// request stream. Every result is checked against a behavioural machine model
// kept in the bench, with random idling on both sides and one long output
// hold-off that backs the unit up.
// ----------------------------------------------------------------------------
module toy_isa_execute_unit_core_tb;
  import tie_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DataWords = 256;
  localparam int NumRandom = 830;
  localparam longint CycleLimit = 64'd3000000;

  typedef struct packed {
    logic [7:0]  func;
    logic [3:0]  fr;
    logic [3:0]  bk;
    logic [15:0] imm;
    logic [15:0] inv;
  } instr_t;

  typedef struct packed {
    logic        dz;
    logic        bad;
    logic        halted;
    logic [15:0] oval;
    logic        ovalid;
    logic [15:0] upper;
    logic [1:0]  flag;
    logic [15:0] ip;
  } outcome_t;

  // directed row: instruction plus an optional hand-typed expectation
  typedef struct {
    instr_t   ins;
    bit       typed;
    outcome_t want;
  } row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;

  toy_isa_execute_unit_core #(.DATA_WORDS(DataWords)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // machine state mirrored by the bench
  logic [15:0] regs [NumRegs];
  logic [15:0] dmem [DataWords];
  logic [15:0] ip;
  logic [1:0]  flag;

  outcome_t pending_q[$];
  row_t     rows[$];
  int       fail_count;
  bit       stim_done;
  bit       quiet;
  bit       hold_off;
  longint   cycles;

  function automatic logic [15:0] loc_rd(logic [3:0] r);
    if (r <= 4) return regs[r];
    return dmem[regs[r] % DataWords];
  endfunction

  function automatic void loc_wr(logic [3:0] r, logic [15:0] v);
    if (r <= 4) regs[r] = v;
    else dmem[regs[r] % DataWords] = v;
  endfunction

  function automatic logic [1:0] signed_cmp(logic [15:0] a, logic [15:0] b);
    if ($signed(a) == $signed(b)) return FLAG_EQ;
    return ($signed(a) > $signed(b)) ? FLAG_GT : FLAG_LT;
  endfunction

  // executes one instruction on the mirrored machine
  function automatic outcome_t execute_instr(instr_t t);
    outcome_t o;
    logic [15:0] old_ip, src, d;
    logic [15:0] q;
    bit take;
    o = '0;
    old_ip = ip;
    ip = old_ip + IpStep;
    if ((t.func >= OP_MOVE && t.func <= OP_CMP) || t.func == OP_IN || t.func == OP_OUT) begin
      if (t.fr > MaxReg) o.bad = 1'b1;
      if (t.func <= OP_CMP && t.bk != 0 && t.bk > MaxReg) o.bad = 1'b1;
    end
    if (t.func == OP_HALT) begin
      o.halted = 1'b1;
    end else if (!o.bad) begin
      src = (t.bk == 0) ? t.imm : ((t.func <= OP_CMP) ? loc_rd(t.bk) : 16'd0);
      case (t.func)
        OP_MOVE: begin
          if (t.bk == 0) regs[t.fr] = t.imm;
          else loc_wr(t.fr, src);
        end
        OP_ADD: loc_wr(t.fr, loc_rd(t.fr) + src);
        OP_SUB: loc_wr(t.fr, loc_rd(t.fr) - src);
        OP_MUL: loc_wr(t.fr, loc_rd(t.fr) * src);
        OP_DIV: begin
          d = loc_rd(t.fr);
          if (src == 0) begin
            o.dz = 1'b1;
          end else begin
            q = 16'($signed(32'(signed'(d))) / $signed(32'(signed'(src))));
            loc_wr(t.fr, q);
          end
        end
        OP_AND, OP_OR, OP_NOT: begin
          if (t.fr == 0 && t.bk != 0) begin
            loc_wr(t.bk, {15'd0, loc_rd(t.bk) == 0});
          end else if (t.fr != 0) begin
            d = loc_rd(t.fr);
            if (t.func == OP_AND) loc_wr(t.fr, {15'd0, d != 0 && src != 0});
            else if (t.func == OP_OR) loc_wr(t.fr, {15'd0, d != 0 || src != 0});
            else if (t.bk == 0) loc_wr(t.fr, {15'd0, d == 0});
          end
        end
        OP_CMP: flag = signed_cmp(loc_rd(t.fr), src);
        OP_JMP: begin
          take = (t.bk == CC_ALWAYS) || (t.bk == CC_EQ && flag == FLAG_EQ) ||
                 (t.bk == CC_GT && flag == FLAG_GT) || (t.bk == CC_LT && flag == FLAG_LT);
          if (take) ip = old_ip + t.imm;
        end
        OP_IN: loc_wr(t.fr, t.inv);
        OP_OUT: begin
          o.ovalid = 1'b1;
          o.oval = loc_rd(t.fr);
        end
        default: ;
      endcase
    end
    o.ip = ip;
    o.flag = flag;
    o.upper = {t.func, t.fr, t.bk};
    return o;
  endfunction

  function automatic instr_t mk(logic [7:0] f, logic [3:0] a, logic [3:0] b,
                                logic [15:0] imm, logic [15:0] inv);
    instr_t t;
    t.func = f; t.fr = a; t.bk = b; t.imm = imm; t.inv = inv;
    return t;
  endfunction

  function automatic void add_row(instr_t t, bit typed, outcome_t w);
    row_t r;
    r.ins = t; r.typed = typed; r.want = w;
    rows.push_back(r);
  endfunction

  // random program item: mostly valid registers, half of the immediates small
  function automatic instr_t rand_instr();
    instr_t t;
    int k;
    k = $urandom_range(0, 99);
    if (k < 4) t.func = 8'($urandom_range(13, 255));
    else if (k < 6) t.func = OP_HALT;
    else t.func = 8'($urandom_range(1, 12));
    t.fr = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    if (t.func == OP_JMP) t.bk = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
    else if ($urandom_range(0, 19) == 0) t.bk = 4'($urandom_range(9, 15));
    else t.bk = ($urandom_range(0, 2) == 0) ? 4'd0 : 4'($urandom_range(1, 8));
    case ($urandom_range(0, 3))
      0: t.imm = 16'($urandom_range(0, 4)) - 16'd2;
      1: t.imm = 16'($urandom_range(0, 300));
      default: t.imm = 16'($urandom);
    endcase
    if (t.func == OP_DIV && $urandom_range(0, 5) == 0) t.imm = 16'hffff;
    t.inv = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
    return t;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("%0t timeout", $time);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // request stream
  initial begin
    row_t   r;
    outcome_t exp_o;
    outcome_t zero_o;
    int n;
    foreach (regs[i]) regs[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    ip = '0; flag = FLAG_EQ;
    fail_count = 0; stim_done = 0; quiet = 0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    zero_o = '0;
    // halt straight after reset
    exp_o = zero_o; exp_o.ip = 16'd4; exp_o.halted = 1'b1;
    add_row(mk(OP_HALT, 0, 0, 0, 0), 1, exp_o);
    // bad register on the destination
    exp_o = zero_o; exp_o.ip = 16'd8; exp_o.bad = 1'b1; exp_o.upper = {OP_MOVE, 4'd15, 4'd0};
    add_row(mk(OP_MOVE, 15, 0, 16'h1234, 0), 1, exp_o);
    // bad register on the source
    exp_o = zero_o; exp_o.ip = 16'd12; exp_o.bad = 1'b1; exp_o.upper = {OP_ADD, 4'd1, 4'd9};
    add_row(mk(OP_ADD, 1, 9, 0, 0), 1, exp_o);
    // divide of a cleared register by a zero immediate
    exp_o = zero_o; exp_o.ip = 16'd16; exp_o.dz = 1'b1; exp_o.upper = {OP_DIV, 4'd1, 4'd0};
    add_row(mk(OP_DIV, 1, 0, 16'd0, 0), 1, exp_o);
    // output of a cleared register
    exp_o = zero_o; exp_o.ip = 16'd20; exp_o.ovalid = 1'b1; exp_o.upper = {OP_OUT, 4'd2, 4'd0};
    add_row(mk(OP_OUT, 2, 0, 0, 0), 1, exp_o);
    add_row(mk(OP_MOVE, 1, 0, 16'h8000, 0), 0, zero_o);
    add_row(mk(OP_DIV, 1, 0, 16'hffff, 0), 0, zero_o);   // overflow wraps
    add_row(mk(OP_MOVE, 5, 0, 16'd7, 0), 0, zero_o);     // immediate to pointer itself
    add_row(mk(OP_IN, 5, 0, 0, 16'h7fff), 0, zero_o);
    add_row(mk(OP_ADD, 5, 0, 16'h7fff, 0), 0, zero_o);
    add_row(mk(OP_MUL, 1, 5, 0, 0), 0, zero_o);
    add_row(mk(OP_SUB, 2, 1, 0, 0), 0, zero_o);
    add_row(mk(OP_AND, 0, 5, 0, 0), 0, zero_o);          // first zero negates second
    add_row(mk(OP_OR, 0, 0, 0, 0), 0, zero_o);           // both zero: nothing
    add_row(mk(OP_NOT, 2, 1, 0, 0), 0, zero_o);          // two registers: nothing
    add_row(mk(OP_NOT, 2, 0, 0, 0), 0, zero_o);
    add_row(mk(OP_AND, 3, 0, 16'hffff, 0), 0, zero_o);
    add_row(mk(OP_OR, 4, 3, 0, 0), 0, zero_o);
    add_row(mk(OP_CMP, 1, 0, 16'h7fff, 0), 0, zero_o);
    add_row(mk(OP_JMP, 9, CC_LT, 16'hfff0, 0), 0, zero_o);
    add_row(mk(OP_JMP, 0, CC_EQ, 16'h0100, 0), 0, zero_o);
    add_row(mk(OP_JMP, 0, 4'd15, 16'h7fff, 0), 0, zero_o);
    add_row(mk(OP_OUT, 8, 0, 0, 0), 0, zero_o);
    add_row(mk(8'hff, 4'hf, 4'hf, 16'hffff, 16'h8000), 0, zero_o);

    n = rows.size() + NumRandom;
    for (int i = 0; i < n; i++) begin
      if (i < rows.size()) r = rows[i];
      else begin
        r.ins = rand_instr(); r.typed = 0;
      end
      quiet = (i > n - 60);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {r.ins.inv, r.ins.imm, r.ins.bk, r.ins.fr, r.ins.func};
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
      exp_o = execute_instr(r.ins);
      if (r.typed && exp_o != r.want) begin
        $display("%0t table row %0d: expected %h, predicted %h", $time, i, r.want, exp_o);
        fail_count++;
      end
      pending_q.push_back(exp_o);
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1;
  end

  // result side: random stalls plus one long hold-off once three results are pending
  initial begin
    int hold;
    hold_off = 0;
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (!hold_off && pending_q.size() >= 3) begin
        hold_off = 1;
        m_axis_tready <= 1'b0;
        for (hold = 0; hold < 600; hold++) @(negedge clk);
      end
      if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // result check
  always @(posedge clk) begin
    outcome_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = outcome_t'(m_axis_tdata[53:0]);
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, got);
        fail_count++;
      end else begin
        want = pending_q.pop_front();
        if (got.ip !== want.ip)
          $display("%0t next_pointer: expected %h, actual %h", $time, want.ip, got.ip);
        if (got.flag !== want.flag)
          $display("%0t compare_result: expected %h, actual %h", $time, want.flag, got.flag);
        if (got.upper !== want.upper)
          $display("%0t instr_upper_half: expected %h, actual %h", $time, want.upper, got.upper);
        if (got.ovalid !== want.ovalid)
          $display("%0t out_valid: expected %b, actual %b", $time, want.ovalid, got.ovalid);
        if (got.oval !== want.oval)
          $display("%0t out_value: expected %h, actual %h", $time, want.oval, got.oval);
        if (got.halted !== want.halted)
          $display("%0t halted: expected %b, actual %b", $time, want.halted, got.halted);
        if (got.bad !== want.bad)
          $display("%0t bad_register: expected %b, actual %b", $time, want.bad, got.bad);
        if (got.dz !== want.dz)
          $display("%0t divide_by_zero: expected %b, actual %b", $time, want.dz, got.dz);
        if (got !== want) fail_count++;
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
